@@ hw/rtl/one_at_a_time_hash_bucket_index_top_assert.svh @@
// Assertion macros shared by the checker.
// Both sample on clk and are switched off while rst is high.
`ifndef ONE_AT_A_TIME_HASH_BUCKET_INDEX_TOP_ASSERT_SVH
`define ONE_AT_A_TIME_HASH_BUCKET_INDEX_TOP_ASSERT_SVH

// Same-cycle implication
`define OHB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ohb check failed");

// Next-cycle implication
`define OHB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ohb check failed");

`endif

@@ hw/rtl/ohb_pkg.sv @@
`default_nettype none
package ohb_pkg;

  // Field and register widths
  localparam int HASH_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int BUCKET_W   = 16;
  localparam int KEYLEN_W   = 13;
  localparam int BCOUNT_W   = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CMP_W      = 17;
  localparam int STEP_W     = $clog2(HASH_W);

  // Defaults and limits
  localparam int DEF_MAX_KEY_BYTES = 4096;
  localparam int KEYLEN_RESET      = 4;
  localparam int BCOUNT_RESET      = 1024;
  localparam int BUCKETS_MAX       = 65536;

  // Register indexes
  localparam logic CFG_KEY_LENGTH   = 1'b0;
  localparam logic CFG_BUCKET_COUNT = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic byte_load;
    logic fin_load;
    logic div_step;
    logic out_load;
  } ohb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic key_end;
    logic div_done;
  } ohb_stat_t;

  // Per-byte mix: add sign-extended byte, shift-add, shift-xor
  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] acc,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] a;
    a = acc + {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    a = a + (a << 10);
    a = a ^ (a >> 6);
    return a;
  endfunction

  // Final avalanche
  function automatic logic [HASH_W-1:0] final_mix(input logic [HASH_W-1:0] acc);
    logic [HASH_W-1:0] h;
    h = acc + (acc << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  // Bucket count clamped to 1..BUCKETS_MAX
  function automatic logic [BCOUNT_W-1:0] eff_buckets(input logic [BCOUNT_W-1:0] bc);
    logic [BCOUNT_W-1:0] n;
    n = bc;
    if (n == '0) n = BCOUNT_W'(1);
    if (n > BCOUNT_W'(BUCKETS_MAX)) n = BCOUNT_W'(BUCKETS_MAX);
    return n;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ohb_dp.sv @@
`default_nettype none
module ohb_dp
  import ohb_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [BYTE_W-1:0]     key_byte,
  input  wire ohb_cmd_t              cmd,
  output ohb_stat_t                  stat,
  output logic [HASH_W-1:0]          hash_out,
  output logic [BUCKET_W-1:0]        bucket_index
);

  localparam int CW = $clog2(MAX_KEY_BYTES + 1);

  logic [KEYLEN_W-1:0] key_length;
  logic [BCOUNT_W-1:0] bucket_count;
  logic [HASH_W-1:0]   accumulator;
  logic [CW-1:0]       byte_count;
  logic [HASH_W-1:0]   hash;
  logic [HASH_W-1:0]   dividend;
  logic [BCOUNT_W-1:0] divisor;
  logic [BCOUNT_W-1:0] rem;
  logic [STEP_W-1:0]   step;

  logic [CMP_W-1:0]    eff_len;
  logic [CMP_W-1:0]    count_inc;
  logic [HASH_W-1:0]   acc_mixed;
  logic [HASH_W-1:0]   hash_fin;
  logic [BCOUNT_W:0]   trial;
  logic [BCOUNT_W:0]   trial_sub;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length   <= KEYLEN_W'(KEYLEN_RESET);
      bucket_count <= BCOUNT_W'(BCOUNT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LENGTH:   key_length   <= cfg_data[KEYLEN_W-1:0];
        CFG_BUCKET_COUNT: bucket_count <= cfg_data[BCOUNT_W-1:0];
      endcase
    end
  end

  // Effective key length and end-of-key detect
  always_comb begin
    eff_len = CMP_W'(key_length);
    if (eff_len == '0) eff_len = CMP_W'(1);
    if (eff_len > CMP_W'(MAX_KEY_BYTES)) eff_len = CMP_W'(MAX_KEY_BYTES);
    count_inc = CMP_W'(byte_count) + CMP_W'(1);
  end

  assign acc_mixed    = mix_byte(accumulator, key_byte);
  assign hash_fin     = final_mix(accumulator);
  assign stat.key_end = (count_inc >= eff_len);
  assign stat.div_done = (step == STEP_W'(HASH_W - 1));

  // Accumulator and byte count; the accumulator keeps the mixed value of the
  // last byte until the final mix picks it up
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      byte_count  <= '0;
    end else if (cmd.byte_load) begin
      accumulator <= acc_mixed;
      byte_count  <= stat.key_end ? '0 : CW'(count_inc);
    end else if (cmd.fin_load) begin
      accumulator <= '0;
    end
  end

  // Restoring divider, one quotient bit a cycle
  assign trial     = {rem, dividend[HASH_W-1]};
  assign trial_sub = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.fin_load) begin
      step <= '0;
    end else if (cmd.div_step) begin
      step <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      hash     <= hash_fin;
      dividend <= hash_fin;
      divisor  <= eff_buckets(bucket_count);
      rem      <= '0;
    end else if (cmd.div_step) begin
      dividend <= dividend << 1;
      if (trial >= {1'b0, divisor}) begin
        rem <= trial_sub[BCOUNT_W-1:0];
      end else begin
        rem <= trial[BCOUNT_W-1:0];
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hash_out     <= hash;
      bucket_index <= rem[BUCKET_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ohb_ctrl.sv @@
`default_nettype none
module ohb_ctrl
  import ohb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  wire logic      m_tready,
  input  wire ohb_stat_t stat,
  output ohb_cmd_t       cmd
);

  localparam logic [1:0] S_ACC  = 2'd0;
  localparam logic [1:0] S_FIN  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Command decode
  always_comb begin
    s_tready      = (state == S_ACC);
    cmd.byte_load = s_tvalid && s_tready;
    cmd.fin_load  = (state == S_FIN);
    cmd.div_step  = (state == S_DIV);
    cmd.out_load  = (state == S_WAIT) && (!m_tvalid || m_tready);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_ACC:  if (cmd.byte_load && stat.key_end) state_next = S_FIN;
      S_FIN:  state_next = S_DIV;
      S_DIV:  if (stat.div_done) state_next = S_WAIT;
      S_WAIT: if (cmd.out_load) state_next = S_ACC;
      default: state_next = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_ACC;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/one_at_a_time_hash_bucket_index_top.sv @@
// A key's bytes are accumulated first, then the final mix, a one-bit-per-cycle
// remainder divider and the output load follow in that order to the result word.
// Bytes of the next key are taken while a finished word waits on m_tready.
// Reset (synchronous, rst high): key_length 4, bucket_count 1024, accumulator and byte count cleared.
`default_nettype none
module one_at_a_time_hash_bucket_index_top
  import ohb_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [7:0] key_byte
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [47:0]                m_tdata,   // [31:0] hash_out, [47:32] bucket_index
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ohb_cmd_t              cmd;
  ohb_stat_t             stat;
  logic [HASH_W-1:0]     hash_out;
  logic [BUCKET_W-1:0]   bucket_index;

  ohb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ohb_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .key_byte     (s_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .hash_out     (hash_out),
    .bucket_index (bucket_index)
  );

  assign m_tdata = {bucket_index, hash_out};

endmodule
`default_nettype wire

@@ hw/rtl/ohb_checker.sv @@
`default_nettype none
`include "one_at_a_time_hash_bucket_index_top_assert.svh"
module ohb_checker
  import ohb_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic [7:0]            s_tdata,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [47:0]           m_tdata,
  input wire logic                  cfg_we,
  input wire logic                  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [BCOUNT_W-1:0] bc_shadow;
  logic                s_take;

  assign s_take = s_tvalid && s_tready && (s_tdata == s_tdata);

  // Shadow of the bucket count register
  always_ff @(posedge clk) begin
    if (rst) begin
      bc_shadow <= BCOUNT_W'(BCOUNT_RESET);
    end else if (cfg_we && (cfg_index == CFG_BUCKET_COUNT)) begin
      bc_shadow <= cfg_data[BCOUNT_W-1:0];
    end
  end

  // A stalled word holds
  `OHB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Bucket index stays below the clamped bucket count
  `OHB_ASSERT_NOW(a_bucket_range, m_tvalid,
                  {1'b0, m_tdata[47:32]} < eff_buckets(bc_shadow))

  // A new word only appears after the divider has run with input closed
  `OHB_ASSERT_NOW(a_rise_after_div, $rose(m_tvalid), !$past(s_take, 1) && !$past(s_tready, 2))

endmodule

bind one_at_a_time_hash_bucket_index_top ohb_checker u_ohb_checker (.*);
`default_nettype wire
